// ===== rtl/weno5z_face_reconstruction_defines.svh =====
// ----------------------------------------------------------------------------
// WENO5-Z face reconstruction assertion macros
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WENO5Z_FACE_RECONSTRUCTION_DEFINES_SVH
`define WENO5Z_FACE_RECONSTRUCTION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WZ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/weno5z_pkg.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z package
// Widths, constants and shared types of the face reconstruction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package weno5z_pkg;

    // Sample format and configuration.
    localparam int SAMPLE_W = 32;
    localparam int EPS_W    = 16;
    localparam int FACES    = 2;
    localparam int TAPS     = 5;
    localparam int SUBS     = 3;

    // Smoothness indicators: B = 6*D^2 + E^2 on integer differences.
    localparam int DIFF_W = SAMPLE_W + 4;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int IND_W  = SQ_W;
    localparam int DEN_W  = IND_W + 1;

    // Ratio |B0-B2| * 2^16 / (Bk + 4*eps), capped to 46 bits.
    localparam int RFRAC   = 16;
    localparam int RATIO_W = 46;
    localparam int RQ_W    = RATIO_W + 1;
    localparam logic [RATIO_W-1:0] RATIO_CAP = '1;

    // Weight numerators and their normalization.
    localparam int ALPHA_W = RATIO_W + 3;
    localparam int SUM_W   = ALPHA_W + 2;
    localparam int NORM_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int W_BITS  = 30;
    localparam int WQ_W    = W_BITS + 1;

    // Candidate blend and final rounding.
    localparam int CAND_W = SAMPLE_W + 6;
    localparam int CMAG_W = CAND_W - 1;
    localparam int PROD_W = CMAG_W + WQ_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int XW     = ACC_W - W_BITS + 1;

    // Divide by six as a halving followed by a multiply with the reciprocal of
    // three. Values at or above the limits clip, so the half stays below 2^34.
    localparam int Y_W       = SAMPLE_W + 2;
    localparam int RCP_SHIFT = Y_W + 1;
    localparam int RCP_W     = Y_W;
    localparam int RCP_HALF  = 17;
    localparam int PL_W      = Y_W + RCP_HALF;
    localparam int PP_W      = Y_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_THIRD =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'd1) / 64'd3);
    localparam logic [XW-1:0] X_POS_LIM = XW'(6) << (SAMPLE_W - 1);
    localparam logic [XW-1:0] X_NEG_LIM = X_POS_LIM + XW'(6);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One result item as it travels to the output buffer.
    typedef struct packed {
        logic [SAMPLE_W-1:0] face_plus_half;
        logic [SAMPLE_W-1:0] face_minus_half;
        logic                saturated;
    } t_face_res;

    // Least right shift that brings the weight sum below 2^NORM_W.
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [SUM_W-1:0] v);
        logic [SHIFT_W-1:0] s;
        s = '0;
        for (int i = NORM_W; i < SUM_W; i++) begin
            if (v[i]) begin
                s = SHIFT_W'(i - NORM_W + 1);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/weno5z_stencil_if.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z stencil channel
// Valid/ready channel that carries one five-point stencil per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface weno5z_stencil_if;
    import weno5z_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_m2;
    logic signed [SAMPLE_W-1:0] sample_m1;
    logic signed [SAMPLE_W-1:0] sample_center;
    logic signed [SAMPLE_W-1:0] sample_p1;
    logic signed [SAMPLE_W-1:0] sample_p2;

    modport source (
        output valid, sample_m2, sample_m1, sample_center, sample_p1, sample_p2,
        input  ready
    );
    modport sink (
        input  valid, sample_m2, sample_m1, sample_center, sample_p1, sample_p2,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/weno5z_face_if.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z face channel
// Valid/ready channel that carries both reconstructed faces per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface weno5z_face_if;
    import weno5z_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] face_plus_half;
    logic signed [SAMPLE_W-1:0] face_minus_half;
    logic                       saturated;

    modport source (
        output valid, face_plus_half, face_minus_half, saturated,
        input  ready
    );
    modport sink (
        input  valid, face_plus_half, face_minus_half, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/weno5z_div.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z pipelined divider
// Restoring division, one quotient bit per stage, several lanes in step,
// with a side bus and a valid bit that travel along with the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module weno5z_div #(
    parameter int LANES = 1,
    parameter int QW    = 8,
    parameter int DW    = 8,
    parameter int PW    = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [LANES-1:0][DW-1:0]     i_rem,
    input  wire logic [LANES-1:0][QW-1:0]     i_low,
    input  wire logic [LANES-1:0][DW-1:0]     i_den,
    input  wire logic [PW-1:0]                i_pass,
    output logic                              o_valid,
    output logic      [LANES-1:0][QW-1:0]     o_quot,
    output logic      [PW-1:0]                o_pass
);

    logic                         r_valid [QW];
    logic [LANES-1:0][DW-1:0]     r_rem   [QW];
    logic [LANES-1:0][QW-1:0]     r_low   [QW];
    logic [LANES-1:0][DW-1:0]     r_den   [QW];
    logic [LANES-1:0][QW-1:0]     r_q     [QW];
    logic [PW-1:0]                r_pass  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic                     src_valid;
        logic [LANES-1:0][DW-1:0] src_rem;
        logic [LANES-1:0][QW-1:0] src_low;
        logic [LANES-1:0][DW-1:0] src_den;
        logic [LANES-1:0][QW-1:0] src_q;
        logic [PW-1:0]            src_pass;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_low;
        logic [LANES-1:0][QW-1:0] n_q;

        // The first stage takes the operands, later ones the previous stage.
        if (g == 0) begin : g_head
            assign src_valid = i_valid;
            assign src_rem   = i_rem;
            assign src_low   = i_low;
            assign src_den   = i_den;
            assign src_q     = '0;
            assign src_pass  = i_pass;
        end else begin : g_body
            assign src_valid = r_valid[g-1];
            assign src_rem   = r_rem[g-1];
            assign src_low   = r_low[g-1];
            assign src_den   = r_den[g-1];
            assign src_q     = r_q[g-1];
            assign src_pass  = r_pass[g-1];
        end

        // Shift in the next numerator bit and subtract where it fits.
        always_comb begin
            logic [DW:0] trial;
            trial = '0;
            for (int l = 0; l < LANES; l++) begin
                trial = {src_rem[l], src_low[l][QW-1]};
                if (trial >= {1'b0, src_den[l]}) begin
                    n_rem[l] = DW'(trial - {1'b0, src_den[l]});
                    n_q[l]   = {src_q[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = trial[DW-1:0];
                    n_q[l]   = {src_q[l][QW-2:0], 1'b0};
                end
                n_low[l] = {src_low[l][QW-2:0], 1'b0};
            end
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= src_valid;
            end
        end

        // Operands and partial quotient of the stage.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_low[g]  <= n_low;
                r_den[g]  <= src_den;
                r_q[g]    <= n_q;
                r_pass[g] <= src_pass;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_pass  = r_pass[QW-1];

endmodule

`default_nettype wire

// ===== rtl/weno5z_outbuf.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z output buffer
// Output register with a skid entry; the pipeline runs while the skid is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module weno5z_outbuf (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire weno5z_pkg::t_face_res  i_data,
    output logic                        o_en,
    output logic                        o_valid,
    output weno5z_pkg::t_face_res       o_data,
    input  wire logic                   i_ready
);
    import weno5z_pkg::*;

    logic      r_head_valid;
    logic      r_skid_valid;
    t_face_res r_head;
    t_face_res r_skid;
    logic      pop;

    assign pop     = r_head_valid && i_ready;
    assign o_en    = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

    // Occupancy of the head and skid entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_head_valid || pop) begin
                r_head_valid <= r_skid_valid || i_push;
            end
            if (r_skid_valid) begin
                r_skid_valid <= !pop;
            end else begin
                r_skid_valid <= i_push && r_head_valid && !pop;
            end
        end
    end

    // Item data: the skid entry drains first, so order is kept.
    always_ff @(posedge i_clk) begin
        if (!r_head_valid || pop) begin
            r_head <= r_skid_valid ? r_skid : i_data;
        end
        if (!r_skid_valid && i_push && r_head_valid && !pop) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/weno5z_face_reconstruction.sv =====
// ----------------------------------------------------------------------------
// WENO5-Z face reconstruction
// Both WENO5-Z face values of one five-point stencil, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_stencil carries one stencil of five signed samples per item; o_face
//   returns the right face, the left face and a saturation flag per item.
//   i_cfg_we with i_cfg_wdata writes the epsilon guard (reset value 1); write
//   it only while no item is in flight. Zero behaves as one.
//   Throughput is one item per clock while o_face is not stalled. Between
//   acceptance and o_face an item passes 5 front stages counting the input
//   capture, a 47-stage ratio divider, 4 weight stages, a 31-stage weight
//   divider, 5 blend stages, 3 stages for the rounding divide by six, the
//   clip stage and the output register.
//   Results leave in acceptance order.
//   Reset clears every valid bit and restores epsilon; stage data is not reset.
//   When the receiver stalls, the result waits in the output register and the
//   pipeline advances one more item into a skid entry; once that entry is
//   full the whole pipeline holds and i_stencil.ready drops until the
//   receiver takes the waiting item.
// ----------------------------------------------------------------------------
`default_nettype none

module weno5z_face_reconstruction (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [weno5z_pkg::EPS_W-1:0]   i_cfg_wdata,
    weno5z_stencil_if.sink                      i_stencil,
    weno5z_face_if.source                       o_face
);
    import weno5z_pkg::*;

    `include "weno5z_face_reconstruction_defines.svh"

    localparam int L1 = FACES * SUBS;
    localparam int L2 = FACES * 2;
    localparam int CF_W = FACES * SUBS * CAND_W;

    logic             w_en;
    logic [EPS_W-1:0] r_eps;
    logic [EPS_W+1:0] eps4;

    // Epsilon register; zero acts as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end
    assign eps4 = {((r_eps == '0) ? EPS_W'(1) : r_eps), 2'b00};

    assign i_stencil.ready = w_en;

    // ---------------- valid bits ----------------
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic r_v6, r_v7, r_v8, r_v9;
    logic r_v10, r_v11, r_v12, r_v13, r_v14;
    logic r_v15, r_v16, r_v17, r_vfin;
    logic d1_valid, d2_valid;

    // ---------------- stage registers ----------------
    logic signed [SAMPLE_W-1:0] r_smp [TAPS];
    logic [MAG_W-1:0]           r_dm [FACES][SUBS];
    logic [MAG_W-1:0]           r_em [FACES][SUBS];
    logic [SQ_W-1:0]            r_dsq [FACES][SUBS];
    logic [SQ_W-1:0]            r_esq [FACES][SUBS];
    logic [IND_W-1:0]           r_ind [FACES][SUBS];
    logic [IND_W-1:0]           r_tau [FACES];
    logic [DEN_W-1:0]           r_den [FACES][SUBS];
    logic [CF_W-1:0]            r_cf1, r_cf2, r_cf3, r_cf4;
    logic [CF_W-1:0]            r_cf6, r_cf7, r_cf8, r_cf9, r_cf10;
    logic [ALPHA_W-1:0]         r_alpha6 [FACES][SUBS];
    logic [ALPHA_W-1:0]         r_alpha7 [FACES][SUBS];
    logic [ALPHA_W-1:0]         r_alpha8 [FACES][SUBS];
    logic [SUM_W-1:0]           r_sum [FACES];
    logic [SHIFT_W-1:0]         r_shift [FACES];
    logic [NORM_W-1:0]          r_as [FACES][SUBS];
    logic [NORM_W-1:0]          r_sum2 [FACES];
    logic [WQ_W-1:0]            r_w [FACES][SUBS];
    logic [PROD_W-1:0]          r_prod [FACES][SUBS];
    logic                       r_pneg [FACES][SUBS];
    logic [ACC_W-1:0]           r_pos [FACES];
    logic [ACC_W-1:0]           r_neg [FACES];
    logic signed [ACC_W:0]      r_diff [FACES];
    logic                       r_negf [FACES];
    logic [ACC_W-1:0]           r_mag [FACES];
    logic                       r_xsat [FACES];
    logic                       r_xneg [FACES];
    logic [Y_W-1:0]             r_y [FACES];
    logic                       r_msat [FACES];
    logic                       r_mneg [FACES];
    logic [PL_W-1:0]            r_plo [FACES];
    logic [PL_W-1:0]            r_phi [FACES];
    logic                       r_qsat [FACES];
    logic                       r_qneg [FACES];
    logic [SAMPLE_W-1:0]        r_q [FACES];
    t_face_res                  r_fin;

    // ---------------- combinational next values ----------------
    logic signed [DIFF_W-1:0]   n_tap [FACES][TAPS];
    logic signed [CAND_W-1:0]   n_ctap [FACES][TAPS];
    logic signed [DIFF_W-1:0]   n_d [FACES][SUBS];
    logic signed [DIFF_W-1:0]   n_e [FACES][SUBS];
    logic [CF_W-1:0]            n_cf;
    logic [XW-1:0]              n_x [FACES];

    // Stencil taps per face: right face in order, left face mirrored.
    always_comb begin
        logic signed [CAND_W-1:0] cand;
        cand = '0;
        n_cf = '0;
        for (int f = 0; f < FACES; f++) begin
            for (int j = 0; j < TAPS; j++) begin
                n_tap[f][j]  = DIFF_W'(r_smp[(f == 0) ? j : (TAPS - 1 - j)]);
                n_ctap[f][j] = CAND_W'(r_smp[(f == 0) ? j : (TAPS - 1 - j)]);
            end
            n_d[f][0] = n_tap[f][0] - (n_tap[f][1] <<< 1) + n_tap[f][2];
            n_e[f][0] = n_tap[f][0] - (n_tap[f][1] <<< 2) + 3 * n_tap[f][2];
            n_d[f][1] = n_tap[f][1] - (n_tap[f][2] <<< 1) + n_tap[f][3];
            n_e[f][1] = n_tap[f][1] - n_tap[f][3];
            n_d[f][2] = n_tap[f][2] - (n_tap[f][3] <<< 1) + n_tap[f][4];
            n_e[f][2] = 3 * n_tap[f][2] - (n_tap[f][3] <<< 2) + n_tap[f][4];
            // Candidate numerators, six times the third-order candidates.
            cand = (n_ctap[f][0] <<< 1) - 7 * n_ctap[f][1] + 11 * n_ctap[f][2];
            n_cf[(f*SUBS+0)*CAND_W +: CAND_W] = cand;
            cand = (n_ctap[f][2] <<< 2) + n_ctap[f][2] - n_ctap[f][1]
                 + (n_ctap[f][3] <<< 1);
            n_cf[(f*SUBS+1)*CAND_W +: CAND_W] = cand;
            cand = (n_ctap[f][2] <<< 1) + 5 * n_ctap[f][3] - n_ctap[f][4];
            n_cf[(f*SUBS+2)*CAND_W +: CAND_W] = cand;
        end
    end

    // Ratio divider operands: |B0-B2| << 16 over Bk + 4*eps.
    logic [L1-1:0][DEN_W-1:0] d1_rem, d1_den;
    logic [L1-1:0][RQ_W-1:0]  d1_low, d1_quot;
    logic [L1-1:0]            d1_ovf;
    logic [L1+CF_W-1:0]       d1_pass_in, d1_pass_out;

    always_comb begin
        for (int f = 0; f < FACES; f++) begin
            for (int k = 0; k < SUBS; k++) begin
                d1_rem[f*SUBS+k] = DEN_W'(r_tau[f] >> (RQ_W - RFRAC));
                d1_low[f*SUBS+k] = {r_tau[f][RQ_W-RFRAC-1:0], {RFRAC{1'b0}}};
                d1_den[f*SUBS+k] = r_den[f][k];
                d1_ovf[f*SUBS+k] = d1_rem[f*SUBS+k] >= r_den[f][k];
            end
        end
        d1_pass_in = {d1_ovf, r_cf4};
    end

    weno5z_div #(.LANES(L1), .QW(RQ_W), .DW(DEN_W), .PW(L1 + CF_W)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_rem   (d1_rem),
        .i_low   (d1_low),
        .i_den   (d1_den),
        .i_pass  (d1_pass_in),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_pass  (d1_pass_out)
    );

    // Weight numerators alpha_k = n_k * (2^16 + r_k), n = 1, 6, 3.
    logic [ALPHA_W-1:0] n_alpha [FACES][SUBS];
    always_comb begin
        logic [RATIO_W-1:0]  r;
        logic [ALPHA_W-1:0]  t;
        r = '0;
        t = '0;
        for (int f = 0; f < FACES; f++) begin
            for (int k = 0; k < SUBS; k++) begin
                if (d1_pass_out[CF_W + f*SUBS + k] || d1_quot[f*SUBS+k][RQ_W-1]) begin
                    r = RATIO_CAP;
                end else begin
                    r = d1_quot[f*SUBS+k][RATIO_W-1:0];
                end
                t = ALPHA_W'(r) + (ALPHA_W'(1) << RFRAC);
                if (k == 0) begin
                    n_alpha[f][k] = t;
                end else if (k == 1) begin
                    n_alpha[f][k] = (t << 2) + (t << 1);
                end else begin
                    n_alpha[f][k] = (t << 1) + t;
                end
            end
        end
    end

    // Weight divider operands: (alpha_k << 30) over the normalized sum.
    logic [L2-1:0][NORM_W-1:0] d2_rem, d2_den;
    logic [L2-1:0][WQ_W-1:0]   d2_low, d2_quot;
    logic [CF_W-1:0]           d2_pass_out;

    always_comb begin
        for (int f = 0; f < FACES; f++) begin
            for (int k = 0; k < 2; k++) begin
                d2_rem[f*2+k] = r_as[f][k] >> 1;
                d2_low[f*2+k] = {r_as[f][k][0], {W_BITS{1'b0}}};
                d2_den[f*2+k] = r_sum2[f];
            end
        end
    end

    weno5z_div #(.LANES(L2), .QW(WQ_W), .DW(NORM_W), .PW(CF_W)) u_div_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v9),
        .i_rem   (d2_rem),
        .i_low   (d2_low),
        .i_den   (d2_den),
        .i_pass  (r_cf9),
        .o_valid (d2_valid),
        .o_quot  (d2_quot),
        .o_pass  (d2_pass_out)
    );

    // Rounded magnitude before the divide by six: (|sum| >> 30) + 3.
    always_comb begin
        for (int f = 0; f < FACES; f++) begin
            n_x[f] = XW'(r_mag[f] >> W_BITS) + XW'(3);
        end
    end

    // Clip each face to the sample range and flag it.
    t_face_res n_fin;
    always_comb begin
        logic [SAMPLE_W-1:0] val [FACES];
        logic                sat;
        sat = 1'b0;
        for (int f = 0; f < FACES; f++) begin
            if (r_qsat[f]) begin
                val[f] = r_qneg[f] ? SAMPLE_MIN : SAMPLE_MAX;
                sat    = 1'b1;
            end else if (r_qneg[f]) begin
                val[f] = ~r_q[f] + SAMPLE_W'(1);
            end else begin
                val[f] = r_q[f];
            end
        end
        n_fin.face_plus_half  = val[0];
        n_fin.face_minus_half = val[1];
        n_fin.saturated       = sat;
    end

    // Valid bits of the stages outside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v9   <= 1'b0;
            r_v10  <= 1'b0;
            r_v11  <= 1'b0;
            r_v12  <= 1'b0;
            r_v13  <= 1'b0;
            r_v14  <= 1'b0;
            r_v15  <= 1'b0;
            r_v16  <= 1'b0;
            r_v17  <= 1'b0;
            r_vfin <= 1'b0;
        end else if (w_en) begin
            r_v0   <= i_stencil.valid;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v6   <= d1_valid;
            r_v7   <= r_v6;
            r_v8   <= r_v7;
            r_v9   <= r_v8;
            r_v10  <= d2_valid;
            r_v11  <= r_v10;
            r_v12  <= r_v11;
            r_v13  <= r_v12;
            r_v14  <= r_v13;
            r_v15  <= r_v14;
            r_v16  <= r_v15;
            r_v17  <= r_v16;
            r_vfin <= r_v17;
        end
    end

    // Stage data; every stage moves together when the pipeline is enabled.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Input capture.
            r_smp[0] <= i_stencil.sample_m2;
            r_smp[1] <= i_stencil.sample_m1;
            r_smp[2] <= i_stencil.sample_center;
            r_smp[3] <= i_stencil.sample_p1;
            r_smp[4] <= i_stencil.sample_p2;

            // Differences as magnitudes, candidates alongside.
            for (int f = 0; f < FACES; f++) begin
                for (int k = 0; k < SUBS; k++) begin
                    r_dm[f][k] <= n_d[f][k][DIFF_W-1] ? MAG_W'(-n_d[f][k]) : MAG_W'(n_d[f][k]);
                    r_em[f][k] <= n_e[f][k][DIFF_W-1] ? MAG_W'(-n_e[f][k]) : MAG_W'(n_e[f][k]);
                end
            end
            r_cf1 <= n_cf;

            // Squares.
            for (int f = 0; f < FACES; f++) begin
                for (int k = 0; k < SUBS; k++) begin
                    r_dsq[f][k] <= {{MAG_W{1'b0}}, r_dm[f][k]} * {{MAG_W{1'b0}}, r_dm[f][k]};
                    r_esq[f][k] <= {{MAG_W{1'b0}}, r_em[f][k]} * {{MAG_W{1'b0}}, r_em[f][k]};
                end
            end
            r_cf2 <= r_cf1;

            // Indicators B = 6*D^2 + E^2.
            for (int f = 0; f < FACES; f++) begin
                for (int k = 0; k < SUBS; k++) begin
                    r_ind[f][k] <= (r_dsq[f][k] << 2) + (r_dsq[f][k] << 1) + r_esq[f][k];
                end
            end
            r_cf3 <= r_cf2;

            // Indicator contrast and guarded denominators.
            for (int f = 0; f < FACES; f++) begin
                r_tau[f] <= (r_ind[f][0] >= r_ind[f][2]) ? (r_ind[f][0] - r_ind[f][2])
                                                         : (r_ind[f][2] - r_ind[f][0]);
                for (int k = 0; k < SUBS; k++) begin
                    r_den[f][k] <= DEN_W'(r_ind[f][k]) + DEN_W'(eps4);
                end
            end
            r_cf4 <= r_cf3;

            // Weight numerators.
            r_alpha6 <= n_alpha;
            r_cf6    <= d1_pass_out[CF_W-1:0];

            // Sum of numerators.
            for (int f = 0; f < FACES; f++) begin
                r_sum[f] <= SUM_W'(r_alpha6[f][0]) + SUM_W'(r_alpha6[f][1])
                          + SUM_W'(r_alpha6[f][2]);
            end
            r_alpha7 <= r_alpha6;
            r_cf7    <= r_cf6;

            // Normalizing shift.
            for (int f = 0; f < FACES; f++) begin
                r_shift[f] <= norm_shift(r_sum[f]);
            end
            r_alpha8 <= r_alpha7;
            r_cf8    <= r_cf7;

            // Shifted numerators and their sum.
            for (int f = 0; f < FACES; f++) begin
                for (int k = 0; k < SUBS; k++) begin
                    r_as[f][k] <= NORM_W'(r_alpha8[f][k] >> r_shift[f]);
                end
                r_sum2[f] <= NORM_W'(r_alpha8[f][0] >> r_shift[f])
                           + NORM_W'(r_alpha8[f][1] >> r_shift[f])
                           + NORM_W'(r_alpha8[f][2] >> r_shift[f]);
            end
            r_cf9 <= r_cf8;

            // Weights; the last one makes them sum to exactly 2^30.
            for (int f = 0; f < FACES; f++) begin
                r_w[f][0] <= d2_quot[f*2];
                r_w[f][1] <= d2_quot[f*2+1];
                r_w[f][2] <= (WQ_W'(1) << W_BITS) - d2_quot[f*2] - d2_quot[f*2+1];
            end
            r_cf10 <= d2_pass_out;

            // Weighted candidate magnitudes.
            for (int f = 0; f < FACES; f++) begin
                for (int k = 0; k < SUBS; k++) begin
                    r_pneg[f][k] <= r_cf10[(f*SUBS+k)*CAND_W + CAND_W - 1];
                    r_prod[f][k] <= (r_cf10[(f*SUBS+k)*CAND_W + CAND_W - 1]
                        ? PROD_W'(CMAG_W'(-r_cf10[(f*SUBS+k)*CAND_W +: CAND_W]))
                        : PROD_W'(r_cf10[(f*SUBS+k)*CAND_W +: CMAG_W]))
                        * PROD_W'(r_w[f][k]);
                end
            end

            // Positive and negative sums.
            for (int f = 0; f < FACES; f++) begin
                r_pos[f] <= (r_pneg[f][0] ? '0 : ACC_W'(r_prod[f][0]))
                          + (r_pneg[f][1] ? '0 : ACC_W'(r_prod[f][1]))
                          + (r_pneg[f][2] ? '0 : ACC_W'(r_prod[f][2]));
                r_neg[f] <= (r_pneg[f][0] ? ACC_W'(r_prod[f][0]) : '0)
                          + (r_pneg[f][1] ? ACC_W'(r_prod[f][1]) : '0)
                          + (r_pneg[f][2] ? ACC_W'(r_prod[f][2]) : '0);
            end

            // Signed blend.
            for (int f = 0; f < FACES; f++) begin
                r_diff[f] <= $signed({1'b0, r_pos[f]}) - $signed({1'b0, r_neg[f]});
            end

            // Sign and magnitude of the blend.
            for (int f = 0; f < FACES; f++) begin
                r_negf[f] <= r_diff[f][ACC_W];
                r_mag[f]  <= r_diff[f][ACC_W] ? ACC_W'(-r_diff[f]) : ACC_W'(r_diff[f]);
            end

            // Range check on the rounded magnitude and its half for the divide.
            for (int f = 0; f < FACES; f++) begin
                r_xsat[f] <= r_negf[f] ? (n_x[f] >= X_NEG_LIM) : (n_x[f] >= X_POS_LIM);
                r_xneg[f] <= r_negf[f];
                r_y[f]    <= n_x[f][Y_W:1];
            end

            // Partial products with the reciprocal of three.
            for (int f = 0; f < FACES; f++) begin
                r_msat[f] <= r_xsat[f];
                r_mneg[f] <= r_xneg[f];
                r_plo[f]  <= PL_W'(r_y[f]) * PL_W'(RCP_THIRD[RCP_HALF-1:0]);
                r_phi[f]  <= PL_W'(r_y[f]) * PL_W'(RCP_THIRD[RCP_W-1:RCP_HALF]);
            end

            // Quotient of the divide by six.
            for (int f = 0; f < FACES; f++) begin
                r_qsat[f] <= r_msat[f];
                r_qneg[f] <= r_mneg[f];
                r_q[f]    <= SAMPLE_W'((PP_W'(r_plo[f]) + (PP_W'(r_phi[f]) << RCP_HALF))
                                       >> RCP_SHIFT);
            end

            // Clipped result.
            r_fin <= n_fin;
        end
    end

    // Output register with skid entry.
    t_face_res w_out;
    weno5z_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && r_vfin),
        .i_data  (r_fin),
        .o_en    (w_en),
        .o_valid (o_face.valid),
        .o_data  (w_out),
        .i_ready (o_face.ready)
    );

    assign o_face.face_plus_half  = w_out.face_plus_half;
    assign o_face.face_minus_half = w_out.face_minus_half;
    assign o_face.saturated       = w_out.saturated;

    // Some face of the waiting item sits at one end of the sample range.
    logic w_at_limit;
    assign w_at_limit = (w_out.face_plus_half == SAMPLE_MAX)
                     || (w_out.face_plus_half == SAMPLE_MIN)
                     || (w_out.face_minus_half == SAMPLE_MAX)
                     || (w_out.face_minus_half == SAMPLE_MIN);

    // A held pipeline always has a result waiting at the output.
    `WZ_ASSERT_SAME(a_stall_has_result, !w_en, o_face.valid, "pipeline held with empty output")

    // An item leaving the pipeline reaches the output.
    `WZ_ASSERT_NEXT(a_leave_lands, w_en && r_vfin, o_face.valid, "finished item lost")

    // A saturated result has a face at one end of the sample range.
    `WZ_ASSERT_SAME(a_sat_at_limit, o_face.valid && o_face.saturated, w_at_limit, "saturated flag without clipped face")

endmodule

`default_nettype wire
